// ----- sv/bmh_pkg.sv -----
// shared types and codes for the binary max-heap
package bmh_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_PEEK    = 2'd1,
    MODE_EXTRACT = 2'd2,
    MODE_DELETE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_LAST   = 2'd0,
    RD_PARENT = 2'd1,
    RD_LEFT   = 2'd2,
    RD_SCAN   = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_VAL   = 2'd0,
    WR_RDA   = 2'd1,
    WR_RDB   = 2'd2
  } wr_sel_e;

  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 48;

  typedef struct packed {
    logic    load;
    logic    ins_start;
    logic    ext_start;
    logic    scan_init;
    logic    scan_dec;
    logic    del_hit;
    logic    take_rd;
    logic    pos_to_parent;
    logic    pos_to_left;
    logic    pos_to_right;
    logic    wr_en;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    logic    out_load;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  is_empty;
    logic  is_full;
    logic  pos_zero;
    logic  up_move;
    logic  dn_left;
    logic  dn_right;
    logic  scan_hit;
    logic  scan_zero;
    logic  del_last;
    logic  del_down;
  } dp_stat_t;

endpackage

// ----- sv/bmh_dp.sv -----
// heap datapath: entry memory, index registers, comparators and result register
module bmh_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmh_pkg::dp_cmd_t  cmd_i,
  output bmh_pkg::dp_stat_t stat_o,
  input  logic [bmh_pkg::InWidth-1:0]  in_data_i,
  output logic [bmh_pkg::OutWidth-1:0] out_data_o
);
  import bmh_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;

  logic signed [31:0] heap_mem_q [CAPACITY];
  logic signed [31:0] rd_a_q, rd_b_q;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] root_q;
  logic [1:0]         mode_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      scan_q, scan_d;
  logic [AW-1:0]      rd_addr_a, rd_addr_b, parent;
  logic [XW-1:0]      lft, rgt, cnt_x;
  logic signed [31:0] wr_data, cand;
  logic               l_ok, r_ok;
  logic [1:0]         out_status_q;
  logic signed [31:0] out_top_q;
  logic [7:0]         out_count_q;

  assign cnt_x  = XW'(cnt_q);
  assign parent = AW'((pos_q - AW'(1)) >> 1);
  assign lft    = XW'({pos_q, 1'b1});
  assign rgt    = lft + XW'(1);
  assign l_ok   = lft < cnt_x;
  assign r_ok   = rgt < cnt_x;

  // larger of the sifted value and a qualifying left child
  assign cand = (l_ok && (rd_a_q > val_q)) ? rd_a_q : val_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_LAST:   rd_addr_a = AW'(cnt_q - CW'(1));
      RD_PARENT: rd_addr_a = parent;
      RD_LEFT:   rd_addr_a = lft[AW-1:0];
      RD_SCAN:   rd_addr_a = scan_q;
      default:   rd_addr_a = scan_q;
    endcase
  end
  assign rd_addr_b = rgt[AW-1:0];

  always_comb begin
    case (cmd_i.wr_sel)
      WR_RDA:  wr_data = rd_a_q;
      WR_RDB:  wr_data = rd_b_q;
      default: wr_data = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      heap_mem_q[pos_q] <= wr_data;
    end
    rd_a_q <= heap_mem_q[rd_addr_a];
    rd_b_q <= heap_mem_q[rd_addr_b];
  end

  always_comb begin
    cnt_d  = cnt_q;
    pos_d  = pos_q;
    scan_d = scan_q;
    val_d  = val_q;
    if (cmd_i.load)          val_d  = signed'(in_data_i[33:2]);
    if (cmd_i.take_rd)       val_d  = rd_a_q;
    if (cmd_i.ins_start) begin
      cnt_d = cnt_q + CW'(1);
      pos_d = AW'(cnt_q);
    end
    if (cmd_i.ext_start) begin
      cnt_d = cnt_q - CW'(1);
      pos_d = '0;
    end
    if (cmd_i.scan_init)     scan_d = AW'(cnt_q - CW'(1));
    if (cmd_i.scan_dec)      scan_d = scan_q - AW'(1);
    if (cmd_i.del_hit) begin
      cnt_d = cnt_q - CW'(1);
      pos_d = scan_q;
    end
    if (cmd_i.pos_to_parent) pos_d = parent;
    if (cmd_i.pos_to_left)   pos_d = lft[AW-1:0];
    if (cmd_i.pos_to_right)  pos_d = rgt[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    scan_q <= scan_d;
    val_q  <= val_d;
    if (cmd_i.load) begin
      mode_q <= in_data_i[1:0];
    end
    // mirror of entry zero for the result
    if (cmd_i.wr_en && (pos_q == '0)) begin
      root_q <= wr_data;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.status;
      out_top_q    <= (cnt_q == '0) ? 32'sd0 : root_q;
      out_count_q  <= 8'(cnt_q);
    end
  end

  assign out_data_o = {6'd0, out_count_q, out_top_q, out_status_q};

  assign stat_o.mode      = mode_e'(mode_q);
  assign stat_o.is_empty  = (cnt_q == '0);
  assign stat_o.is_full   = (cnt_q == CW'(CAPACITY));
  assign stat_o.pos_zero  = (pos_q == '0);
  assign stat_o.up_move   = (rd_a_q < val_q);
  assign stat_o.dn_left   = l_ok && (rd_a_q > val_q);
  assign stat_o.dn_right  = r_ok && (rd_b_q > cand);
  assign stat_o.scan_hit  = (rd_a_q == val_q);
  assign stat_o.scan_zero = (scan_q == '0);
  assign stat_o.del_last  = (XW'(pos_q) == cnt_x);
  assign stat_o.del_down  = (val_q > rd_a_q);

`ifndef ASSERT_OFF
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_wr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (XW'(pos_q) < cnt_x))
    else $error("write outside live entries");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_start |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the count");
`endif

endmodule

// ----- sv/bmh_ctrl.sv -----
// heap sequencer: decodes the operation and steps the sift and search loops
module bmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  bmh_pkg::dp_stat_t stat_i,
  output bmh_pkg::dp_cmd_t  cmd_o
);
  import bmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHK,
    S_UP_CMP,
    S_EXT_LD,
    S_DN_RD,
    S_DN_CMP,
    S_SRD,
    S_SCMP,
    S_DEL_LD,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = status_q;
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          status_d   = ST_OK;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.mode)
          MODE_INSERT: begin
            if (stat_i.is_full) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = S_UP_CHK;
            end
          end
          MODE_PEEK: begin
            if (stat_i.is_empty) status_d = ST_EMPTY;
            state_d = S_DONE;
          end
          MODE_EXTRACT: begin
            if (stat_i.is_empty) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              cmd_o.rd_sel    = RD_LAST;
              cmd_o.ext_start = 1'b1;
              state_d         = S_EXT_LD;
            end
          end
          default: begin
            if (stat_i.is_empty) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SRD;
            end
          end
        endcase
      end
      S_UP_CHK: begin
        if (stat_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_VAL;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_move) begin
          // parent drops into the hole, hole climbs
          cmd_o.wr_sel        = WR_RDA;
          cmd_o.pos_to_parent = 1'b1;
          state_d             = S_UP_CHK;
        end else begin
          cmd_o.wr_sel = WR_VAL;
          state_d      = S_DONE;
        end
      end
      S_EXT_LD: begin
        cmd_o.take_rd = 1'b1;
        state_d       = stat_i.is_empty ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        cmd_o.rd_sel = RD_LEFT;
        state_d      = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.dn_right) begin
          cmd_o.wr_sel       = WR_RDB;
          cmd_o.pos_to_right = 1'b1;
          state_d            = S_DN_RD;
        end else if (stat_i.dn_left) begin
          cmd_o.wr_sel      = WR_RDA;
          cmd_o.pos_to_left = 1'b1;
          state_d           = S_DN_RD;
        end else begin
          cmd_o.wr_sel = WR_VAL;
          state_d      = S_DONE;
        end
      end
      S_SRD: begin
        cmd_o.rd_sel = RD_SCAN;
        state_d      = S_SCMP;
      end
      S_SCMP: begin
        // searching from the top index down, so the first hit is the highest
        if (stat_i.scan_hit) begin
          cmd_o.rd_sel  = RD_LAST;
          cmd_o.del_hit = 1'b1;
          state_d       = S_DEL_LD;
        end else if (stat_i.scan_zero) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          cmd_o.scan_dec = 1'b1;
          state_d        = S_SRD;
        end
      end
      S_DEL_LD: begin
        if (stat_i.del_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.take_rd = 1'b1;
          state_d       = stat_i.del_down ? S_DN_RD : S_UP_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;

`ifndef ASSERT_OFF
  a_load_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_DISPATCH))
    else $error("item taken outside idle");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE) && m_axis_tvalid)
    else $error("result not presented after load");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && out_valid_q) |-> m_axis_tready)
    else $error("pending result overwritten");
`endif

endmodule

// ----- sv/binary_max_heap.sv -----
// top level of the bounded binary max-heap priority queue
//
//   port group   dir   beat contents (lowest bit first)
//   s_axis_*     in    mode[1:0], value[33:2], zero pad to 40 bits
//   m_axis_*     out   status[1:0], top_value[33:2], count[41:34], zero pad to 48
//
// one item is in flight at a time; peek goes straight to its result
// insert climbs one level per read and compare, ending at the root or where it stops below it
// extract sinks one level per read and compare, and ends early when it empties the heap
// delete searches entries from the highest index down, then the sift
// every sift level costs one registered memory read and one compare/write step
// reset clears the entry count and the sequencer state; the entry memory itself is not cleared
// a stalled result holds in the output register while the next item is taken and run
module binary_max_heap #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // mode[1:0], value[33:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], top_value[33:2], count[41:34]
);
  import bmh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  bmh_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- tb/sv/binary_max_heap_test.sv -----
// testbench for the binary max-heap: directed and random heap traffic checked beat by beat
`timescale 1ns / 100ps

module binary_max_heap_test;
  import bmh_pkg::*;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned DRAIN_CYCLES = 300;

  // status in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic [7:0]         count;
    logic signed [31:0] top_value;
    status_e            status;
  } heap_result_t;

  class heap_scoreboard;
    int           slots[CAPACITY];
    int unsigned  fill;
    heap_result_t pending[$];
    int unsigned  errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void exchange(int unsigned a, int unsigned b);
      int t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void bubble_up(int unsigned pos);
      int unsigned up;
      while (pos > 0 && pos < CAPACITY) begin
        up = (pos - 1) / 2;
        if (slots[up] < slots[pos]) begin
          exchange(up, pos);
          pos = up;
        end else begin
          break;
        end
      end
    endfunction

    function void bubble_down(int unsigned pos);
      int unsigned best;
      int unsigned l;
      int unsigned r;
      while (pos < fill) begin
        best = pos;
        l = pos * 2 + 1;
        r = pos * 2 + 2;
        if (l < fill && slots[l] > slots[best]) best = l;
        if (r < fill && slots[r] > slots[best]) best = r;
        if (best == pos) break;
        exchange(best, pos);
        pos = best;
      end
    endfunction

    // apply one accepted command beat and queue the result it must produce
    function void note_input(mode_e mode, logic signed [31:0] value);
      heap_result_t res;
      int unsigned  hit;
      bit           found;
      int           removed;
      int           moved;
      res.status = ST_OK;
      case (mode)
        MODE_INSERT: begin
          if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            slots[fill] = value;
            fill++;
            bubble_up(fill - 1);
          end
        end
        MODE_PEEK: begin
          if (fill == 0) res.status = ST_EMPTY;
        end
        MODE_EXTRACT: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            slots[0] = slots[fill - 1];
            fill--;
            bubble_down(0);
          end
        end
        default: begin
          // the match with the highest index is the one removed
          found = 1'b0;
          hit = 0;
          for (int unsigned i = 0; i < fill; i++) begin
            if (slots[i] == value) begin
              hit = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            res.status = ST_NOT_FOUND;
          end else begin
            removed = slots[hit];
            moved = slots[fill - 1];
            slots[hit] = moved;
            fill--;
            if (hit < fill) begin
              if (removed > moved) bubble_down(hit);
              else bubble_up(hit);
            end
          end
        end
      endcase
      res.top_value = (fill != 0) ? slots[0] : 32'sd0;
      res.count = fill[7:0];
      pending.push_back(res);
    endfunction

    function void check_result(logic [47:0] beat);
      heap_result_t got;
      heap_result_t want;
      got = heap_result_t'(beat[41:0]);
      if (pending.size() == 0) begin
        $error("result beat with no command outstanding: %h", beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.top_value !== want.top_value) begin
        $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  heap_scoreboard sb = new();
  int unsigned    results_seen;
  int unsigned    quiet_cycles;
  bit             tx_steady;

  binary_max_heap #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_cmd(mode_e mode, logic signed [31:0] value);
    while (!tx_steady && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, value, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(mode, value);
  endtask

  // mix of duplicates-prone small keys, extremes and full-range keys
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(3))
      0: return $signed($urandom_range(8)) - 32'sd4;
      1: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // mostly keys that are present, so deletes usually hit
  function automatic logic signed [31:0] pick_victim();
    if (sb.fill > 0 && $urandom_range(9) < 8) return sb.slots[$urandom_range(sb.fill - 1)];
    return pick_key();
  endfunction

  task automatic random_phase(int unsigned n_items, int unsigned insert_pct,
                              inout int unsigned sent);
    int unsigned roll;
    for (int unsigned i = 0; i < n_items && sent < RANDOM_ITEMS; i++) begin
      tx_steady = (sent >= 300 && sent < 600);
      roll = $urandom_range(99);
      if (roll < insert_pct) begin
        send_cmd(MODE_INSERT, pick_key());
      end else begin
        roll = $urandom_range(9);
        if (roll < 2) send_cmd(MODE_PEEK, $urandom);
        else if (roll < 6) send_cmd(MODE_EXTRACT, $urandom);
        else send_cmd(MODE_DELETE, pick_victim());
      end
      sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    tx_steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty heap corner cases
    send_cmd(MODE_PEEK, 32'sd0);
    send_cmd(MODE_EXTRACT, -32'sd1);
    send_cmd(MODE_DELETE, 32'sd5);
    // extremes and equal keys
    send_cmd(MODE_INSERT, 32'sh7FFF_FFFF);
    send_cmd(MODE_INSERT, 32'sh8000_0000);
    send_cmd(MODE_INSERT, 32'sd0);
    send_cmd(MODE_INSERT, -32'sd1);
    send_cmd(MODE_INSERT, 32'sh7FFF_FFFF);
    send_cmd(MODE_INSERT, 32'sd3);
    send_cmd(MODE_INSERT, 32'sd3);
    send_cmd(MODE_PEEK, 32'sh5A5A_5A5A);
    send_cmd(MODE_DELETE, 32'sd3);
    send_cmd(MODE_DELETE, 32'sh8000_0000);
    send_cmd(MODE_DELETE, 32'sd12345);
    // smallest key lands in the last slot, so its delete needs no sift
    send_cmd(MODE_INSERT, -32'sd5);
    send_cmd(MODE_DELETE, -32'sd5);
    send_cmd(MODE_INSERT, 32'sh5555_5555);
    send_cmd(MODE_INSERT, 32'shAAAA_AAAA);
    send_cmd(MODE_DELETE, 32'sh5555_5555);
    repeat (7) send_cmd(MODE_EXTRACT, 32'sd0);
    send_cmd(MODE_PEEK, 32'sd0);

    // fill to capacity first, then drain, then random mixes
    sent = 0;
    random_phase(250, 85, sent);
    random_phase(220, 10, sent);
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0: random_phase($urandom_range(200, 60), 80, sent);
        1: random_phase($urandom_range(200, 60), 15, sent);
        default: random_phase($urandom_range(200, 60), 45, sent);
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    results_seen = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        results_seen++;
        // one long back-pressure stretch so the heap stalls its input
        if (results_seen == 500) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_seen >= 900 && results_seen < 1100) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
